[rtl/core/swarq_pkg.sv]
// swarq_pkg: shared types, codes and helper functions of the sliding-window ARQ sender
// no dependencies; imported by every module of the block
package swarq_pkg;

	// fixed field widths
	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned FRAME_W    = 8;
	localparam int unsigned ACT_W      = 2;
	localparam int unsigned WIN_REG_W  = 5;
	localparam int unsigned TOT_REG_W  = 9;
	localparam int unsigned RESULT_CAP = 16;

	// configuration port
	localparam int unsigned CFG_IW = 3;
	localparam int unsigned CFG_DW = 9;

	localparam logic [CFG_IW-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IW-1:0] REG_WIN_LEN     = 3'd1;
	localparam logic [CFG_IW-1:0] REG_TOTAL       = 3'd2;
	localparam logic [CFG_IW-1:0] REG_LOST_FRAME  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_LOSS_ENABLE = 3'd4;

	localparam logic [WIN_REG_W-1:0] RST_WIN_LEN = 5'd4;
	localparam logic [TOT_REG_W-1:0] RST_TOTAL   = 9'd8;

	// event codes
	localparam logic [FUNC_W-1:0] FUNC_START   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

	// action codes
	localparam logic [ACT_W-1:0] ACT_NEW  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOST = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RETX = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	// mode codes
	localparam logic MODE_GBN = 1'b0;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_ACK,
		CMD_TIMEOUT,
		CMD_NONE
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [FRAME_W-1:0] ack_number;
	} in_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_number;
		logic [ACT_W-1:0]   action;
		logic               ack_ignored;
		logic               all_done;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic                 mode;
		logic [WIN_REG_W-1:0] win_len;
		logic [TOT_REG_W-1:0] frame_count;
		logic [FRAME_W-1:0]   lost_frame;
		logic                 loss_enable;
	} cfg_t;

	// classified event between front and back
	typedef struct packed {
		cmd_t               cmd;
		logic [FRAME_W-1:0] ack_number;
		logic               out_of_range;
	} qitem_t;

	// frame count clipped to the frame capacity
	function automatic int unsigned eff_total(logic [TOT_REG_W-1:0] tf, int unsigned max_frames);
		int unsigned t;
		t = int'(tf);
		if (t > max_frames) begin
			t = max_frames;
		end
		return t;
	endfunction

	// window size forced into one to cap
	function automatic int unsigned eff_window(logic [WIN_REG_W-1:0] ws, int unsigned cap);
		int unsigned w;
		w = int'(ws);
		if (w < 1) begin
			w = 1;
		end
		if (w > cap) begin
			w = cap;
		end
		return w;
	endfunction

endpackage

[rtl/core/sliding_window_arq_sender.sv]
// sliding_window_arq_sender: top level with configuration registers, front, queue and back
// depends on swarq_pkg, swarq_front, swarq_queue, swarq_back
//
// Sender side of a sliding-window ARQ, Go-Back-N (mode 0) or Selective Repeat (mode 1).
// Each event (start, acknowledgement, timeout) yields between one and sixteen result
// transactions, the final one flagged by last; an event with nothing to send yields a
// single "nothing to send" result. The back sequencer steps through dequeue, window
// update and run setup for each event and then emits one result per cycle while the
// output is not stalled. A front register and a two-entry event queue keep accepting
// events while the back is busy. The acknowledgement map is kept as a window-wide
// bitmap aligned to the window base, so a start clears the run in a single register
// write with no clearing pass. The user must write configuration only while no event
// is in flight; the block itself does not enforce it.
module sliding_window_arq_sender #(
	parameter int unsigned MAX_FRAMES = 256,
	parameter int unsigned MAX_WINDOW = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  swarq_pkg::in_item_t                in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output swarq_pkg::out_item_t               out_data,
	input  logic                               cfg_we,
	input  logic [swarq_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [swarq_pkg::CFG_DW-1:0]       cfg_data
);
	import swarq_pkg::*;

	cfg_t   cfg_q;
	logic   q_push;
	logic   q_ready;
	logic   q_pop;
	logic   q_valid;
	qitem_t q_wr_item;
	qitem_t q_rd_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_GBN;
			cfg_q.win_len     <= RST_WIN_LEN;
			cfg_q.frame_count <= RST_TOTAL;
			cfg_q.lost_frame  <= '0;
			cfg_q.loss_enable <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:        cfg_q.mode        <= cfg_data[0];
				REG_WIN_LEN:     cfg_q.win_len     <= cfg_data[WIN_REG_W-1:0];
				REG_TOTAL:       cfg_q.frame_count <= cfg_data[TOT_REG_W-1:0];
				REG_LOST_FRAME:  cfg_q.lost_frame  <= cfg_data[FRAME_W-1:0];
				REG_LOSS_ENABLE: cfg_q.loss_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// event intake and classification
	swarq_front #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_item   (q_wr_item)
	);

	// event queue
	swarq_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.ready   (q_ready),
		.pop     (q_pop),
		.valid   (q_valid),
		.rd_item (q_rd_item)
	);

	// window state and frame action sequencer
	swarq_back #(
		.MAX_FRAMES(MAX_FRAMES),
		.MAX_WINDOW(MAX_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_rd_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[rtl/core/swarq_front.sv]
// swarq_front: accepts input events, decodes the event kind and range-checks the ack number
// depends on swarq_pkg; feeds swarq_queue
module swarq_front #(
	parameter int unsigned MAX_FRAMES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  swarq_pkg::cfg_t   cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  swarq_pkg::in_item_t in_data,
	input  logic              q_ready,
	output logic              q_push,
	output swarq_pkg::qitem_t q_item
);
	import swarq_pkg::*;

	localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

	logic          valid_s1;
	qitem_t        item_s1;
	qitem_t        item_c;
	logic [CW-1:0] total_eff;
	logic          accept;

	// classify the incoming event
	always_comb begin
		total_eff = CW'(eff_total(cfg.frame_count, MAX_FRAMES));
		item_c.ack_number = in_data.ack_number;
		item_c.out_of_range = (32'(in_data.ack_number) >= 32'(total_eff));
		case (in_data.func)
			FUNC_START:   item_c.cmd = CMD_START;
			FUNC_ACK:     item_c.cmd = CMD_ACK;
			FUNC_TIMEOUT: item_c.cmd = CMD_TIMEOUT;
			default:      item_c.cmd = CMD_NONE;
		endcase
	end

	assign in_stall = valid_s1 && !q_ready;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1;
	assign q_item   = item_s1;

	// one registered slot ahead of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule

[rtl/core/swarq_queue.sv]
// swarq_queue: two-entry queue of classified events between front and back
// depends on swarq_pkg
module swarq_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  swarq_pkg::qitem_t wr_item,
	output logic              ready,
	input  logic              pop,
	output logic              valid,
	output swarq_pkg::qitem_t rd_item
);
	import swarq_pkg::*;

	qitem_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign ready   = (cnt_q != 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign do_push = push && ready;
	assign do_pop  = pop && valid;
	assign rd_item = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_item;
		end
	end

endmodule

[rtl/core/swarq_back.sv]
// swarq_back: window state and sequencer that applies each event and emits its frame actions
// depends on swarq_pkg; takes events from swarq_queue
module swarq_back #(
	parameter int unsigned MAX_FRAMES = 256,
	parameter int unsigned MAX_WINDOW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swarq_pkg::cfg_t      cfg,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  swarq_pkg::qitem_t    q_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output swarq_pkg::out_item_t out_data
);
	import swarq_pkg::*;

	localparam int unsigned EW = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;
	localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
	localparam int unsigned LW = CW + 1;
	localparam int unsigned SW = $clog2(EW + 1);
	localparam int unsigned KW = (EW > 1) ? $clog2(EW) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SETUP,
		ST_EMIT
	} state_t;

	state_t             st_q;
	cmd_t               cmd_q;
	logic [FRAME_W-1:0] ack_q;
	logic               oor_q;
	logic               ignored_q;
	logic               done_q;
	logic               retx_q;
	logic               empty_q;
	logic [EW-1:0]      mask_q;
	logic [CW-1:0]      origin_q;
	logic [CW-1:0]      base_q;
	logic [CW-1:0]      next_q;
	logic               loss_used_q;
	// bit k: frame base_q + k has been acknowledged
	logic [EW-1:0]      acked_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic [CW-1:0]  total_eff;
	logic [SW-1:0]  win_eff;
	logic [CW-1:0]  ack_ext;
	logic           ack_ge_base;
	logic           ignored_c;
	logic [SW-1:0]  delta_c;
	logic [SW-1:0]  gbn_shift_c;
	logic [EW-1:0]  set_map_c;
	logic [SW-1:0]  ones_c;
	logic [CW-1:0]  room_c;
	logic [SW-1:0]  slide_c;
	logic [LW-1:0]  lim_c;
	logic [LW-1:0]  hi_c;
	logic [SW-1:0]  fill_span_c;
	logic [SW-1:0]  retx_span_c;
	logic [EW-1:0]  mask_c;
	logic [KW-1:0]  pick_c;
	logic [EW-1:0]  rest_c;
	logic [LW-1:0]  frame_c;
	logic           loss_hit_c;
	logic           can_load;
	out_item_t      item_c;

	// low span bits set
	function automatic logic [EW-1:0] span_mask(logic [SW-1:0] span);
		logic [EW:0] t;
		t = ((EW + 1)'(1) << span) - (EW + 1)'(1);
		return t[EW-1:0];
	endfunction

	assign total_eff = CW'(eff_total(cfg.frame_count, MAX_FRAMES));
	assign win_eff   = SW'(eff_window(cfg.win_len, EW));
	assign q_pop     = (st_q == ST_IDLE) && q_valid;
	assign can_load  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// acknowledgement update
	always_comb begin
		ack_ext     = CW'(ack_q);
		ack_ge_base = (32'(ack_q) >= 32'(base_q));
		ignored_c   = oor_q || (32'(ack_q) >= 32'(next_q));
		delta_c     = SW'(ack_ext - base_q);
		gbn_shift_c = delta_c + SW'(1);
		set_map_c   = acked_q | (ack_ge_base ? (EW'(1) << delta_c) : '0);
		// trailing acknowledged frames from the base
		ones_c = SW'(EW);
		for (int k = EW - 1; k >= 0; k--) begin
			if (!set_map_c[k]) begin
				ones_c = SW'(k);
			end
		end
		room_c = (base_q < total_eff) ? (total_eff - base_q) : '0;
		slide_c = (32'(ones_c) > 32'(room_c)) ? SW'(room_c) : ones_c;
	end

	// span of the frame run for this event
	always_comb begin
		lim_c = LW'(base_q) + LW'(win_eff);
		if (lim_c > LW'(total_eff)) begin
			lim_c = LW'(total_eff);
		end
		hi_c = (lim_c < LW'(next_q)) ? lim_c : LW'(next_q);
		fill_span_c = (lim_c > LW'(next_q)) ? SW'(lim_c - LW'(next_q)) : '0;
		retx_span_c = (hi_c > LW'(base_q)) ? SW'(hi_c - LW'(base_q)) : '0;
		case (cmd_q)
			CMD_START, CMD_ACK: mask_c = span_mask(fill_span_c);
			CMD_TIMEOUT: begin
				if (cfg.mode == MODE_GBN) begin
					mask_c = span_mask(retx_span_c);
				end else begin
					mask_c = span_mask(retx_span_c) & ~acked_q;
				end
			end
			default: mask_c = '0;
		endcase
	end

	// next frame action of the run
	always_comb begin
		pick_c = '0;
		for (int k = EW - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				pick_c = KW'(k);
			end
		end
		rest_c  = mask_q & ~(EW'(1) << pick_c);
		frame_c = LW'(origin_q) + LW'(pick_c);
		loss_hit_c = cfg.loss_enable && !loss_used_q
			&& (32'(frame_c) == 32'(cfg.lost_frame));
		item_c.ack_ignored = ignored_q;
		item_c.all_done    = done_q;
		if (empty_q) begin
			item_c.frame_number = '0;
			item_c.action       = ACT_NONE;
			item_c.last         = 1'b1;
		end else begin
			item_c.frame_number = FRAME_W'(frame_c);
			item_c.last         = (rest_c == '0);
			if (retx_q) begin
				item_c.action = ACT_RETX;
			end else if (loss_hit_c) begin
				item_c.action = ACT_LOST;
			end else begin
				item_c.action = ACT_NEW;
			end
		end
	end

	// sequencer, window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cmd_q       <= CMD_NONE;
			ack_q       <= '0;
			oor_q       <= 1'b0;
			ignored_q   <= 1'b0;
			done_q      <= 1'b0;
			retx_q      <= 1'b0;
			empty_q     <= 1'b0;
			mask_q      <= '0;
			origin_q    <= '0;
			base_q      <= '0;
			next_q      <= '0;
			loss_used_q <= 1'b0;
			acked_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// result taken and nothing new offered this cycle
			if (out_valid_q && !out_stall && st_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q <= q_item.cmd;
						ack_q <= q_item.ack_number;
						oor_q <= q_item.out_of_range;
						st_q  <= ST_PREP;
					end
				end
				ST_PREP: begin
					case (cmd_q)
						CMD_START: begin
							ignored_q   <= 1'b0;
							base_q      <= '0;
							next_q      <= '0;
							loss_used_q <= 1'b0;
							acked_q     <= '0;
						end
						CMD_ACK: begin
							ignored_q <= ignored_c;
							if (!ignored_c) begin
								if (cfg.mode == MODE_GBN) begin
									if (ack_ge_base) begin
										base_q  <= base_q + CW'(gbn_shift_c);
										acked_q <= acked_q >> gbn_shift_c;
									end
								end else begin
									base_q  <= base_q + CW'(slide_c);
									acked_q <= set_map_c >> slide_c;
								end
							end
						end
						default: ignored_q <= 1'b0;
					endcase
					st_q <= ST_SETUP;
				end
				ST_SETUP: begin
					done_q  <= (base_q >= total_eff);
					mask_q  <= mask_c;
					empty_q <= (mask_c == '0);
					retx_q  <= (cmd_q == CMD_TIMEOUT);
					if (cmd_q == CMD_TIMEOUT) begin
						origin_q <= base_q;
					end else begin
						origin_q <= next_q;
					end
					if (cmd_q == CMD_START || cmd_q == CMD_ACK) begin
						next_q <= next_q + CW'(fill_span_c);
					end
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						out_data_q  <= item_c;
						mask_q      <= rest_c;
						if (!empty_q && !retx_q && loss_hit_c) begin
							loss_used_q <= 1'b1;
						end
						if (item_c.last) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/swarq_checker.sv]
// swarq_checker: port-level assertions on the result channel of the ARQ sender
// depends on swarq_pkg; bound to sliding_window_arq_sender
module swarq_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input swarq_pkg::out_item_t out_data
);
	import swarq_pkg::*;

	// a stalled result stays offered
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// a stalled result keeps its payload
	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result payload changed while stalled");

	// nothing-to-send is a lone final result on frame zero
	a_none_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.action == ACT_NONE) |->
			out_data.last && (out_data.frame_number == '0))
		else $error("nothing-to-send result not alone");

	// a timeout never flags an ignored acknowledgement
	a_retx_not_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.action == ACT_RETX) |-> !out_data.ack_ignored)
		else $error("retransmit carries ack_ignored");

endmodule

bind sliding_window_arq_sender swarq_checker u_swarq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
